[rtl/core/csfp_pkg.sv]
// Package for the color sensor frame parser: frame constants, parse phase
// encoding and the RGB result type. No dependencies.
`timescale 1ns / 1ps

package csfp_pkg;

   // Absorb limit for one frame, sync bytes included (8 to 64)
   localparam int FRAME_BUF_BYTES = 16;
   localparam int CNT_W           = $clog2(FRAME_BUF_BYTES + 1);

   localparam logic [7:0] SYNC_BYTE   = 8'h5A;
   localparam logic [7:0] RGB_TYPE    = 8'h45;
   localparam logic [7:0] RGB_COUNT   = 8'd3;
   localparam logic [7:0] COUNT_LIMIT = 8'd12;

   // Frame byte positions, counted from 1 with the syncs included
   localparam int TYPE_POS   = 3;
   localparam int COUNT_POS  = 4;
   localparam int HEAD_BYTES = 4;
   localparam int HEAD_DEPTH = 3;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'b001,
      PH_SYNC2 = 3'b010,
      PH_BODY  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_type;

endpackage

[rtl/core/csfp_parser.sv]
// Frame parser core: parse phase, byte counter, running checksum and the
// first payload bytes. Depends on csfp_pkg.
`timescale 1ns / 1ps

module csfp_parser
   import csfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       hit,
   output rgb_type    rgb
);

   localparam int CMP_W = 9;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       plen_ff, plen_in;
   logic [7:0]       head_ff [HEAD_DEPTH];

   logic [CNT_W-1:0] n;
   logic [CNT_W-1:0] head_idx;
   logic             head_wr;
   logic             done;
   logic             at_limit;

   assign n        = count_ff + CNT_W'(1);
   assign head_idx = n - CNT_W'(HEAD_BYTES + 1);
   assign at_limit = n >= CNT_W'(FRAME_BUF_BYTES);
   assign done     = (plen_ff <= COUNT_LIMIT) &&
                     (CMP_W'(n) >= CMP_W'(plen_ff) + CMP_W'(HEAD_BYTES + 1));

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      type_in  = type_ff;
      plen_in  = plen_ff;
      head_wr  = 1'b0;
      hit      = 1'b0;
      unique case (phase_ff)
         PH_SYNC2: begin
            if (rx_byte == SYNC_BYTE) begin
               phase_in = PH_BODY;
               count_in = CNT_W'(2);
               sum_in   = SYNC_BYTE + SYNC_BYTE;
            end else begin
               phase_in = PH_HUNT;
               count_in = '0;
            end
         end
         PH_BODY: begin
            count_in = n;
            if (n == CNT_W'(TYPE_POS)) begin
               type_in = rx_byte;
               sum_in  = sum_ff + rx_byte;
            end else if (n == CNT_W'(COUNT_POS)) begin
               plen_in = rx_byte;
               sum_in  = sum_ff + rx_byte;
               if (at_limit) begin
                  phase_in = PH_HUNT;
                  count_in = '0;
               end
            end else if (done) begin
               // checksum byte: emit only a good RGB frame, drop the rest
               hit      = (sum_ff == rx_byte) && (type_ff == RGB_TYPE) &&
                          (plen_ff == RGB_COUNT);
               phase_in = PH_HUNT;
               count_in = '0;
            end else if (at_limit) begin
               phase_in = PH_HUNT;
               count_in = '0;
            end else begin
               sum_in  = sum_ff + rx_byte;
               head_wr = (n >= CNT_W'(HEAD_BYTES + 1)) &&
                         (head_idx < CNT_W'(HEAD_DEPTH));
            end
         end
         default: begin
            // hunt, and any unreachable code behaves like hunt
            if (rx_byte == SYNC_BYTE) begin
               phase_in = PH_SYNC2;
               count_in = CNT_W'(1);
            end else begin
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   assign rgb.red   = head_ff[0];
   assign rgb.green = head_ff[1];
   assign rgb.blue  = head_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         type_ff <= type_in;
         plen_ff <= plen_in;
         if (head_wr) begin
            head_ff[head_idx[1:0]] <= rx_byte;
         end
      end
   end

   a_sync2_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SYNC2 |-> count_ff == CNT_W'(1))
      else $error("second-sync phase with wrong byte count");

   a_body_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |->
         count_ff >= CNT_W'(2) && count_ff < CNT_W'(FRAME_BUF_BYTES))
      else $error("body byte count outside the absorb window");

   a_hit_body: assert property (@(posedge clock) disable iff (reset)
      hit |-> phase_ff == PH_BODY && count_ff == CNT_W'(HEAD_BYTES + 3))
      else $error("RGB result outside a checksum byte");

endmodule

[rtl/core/csfp_out_stage.sv]
// Result register of the frame parser with stream handshake toward the sink.
// Depends on csfp_pkg.
`timescale 1ns / 1ps

module csfp_out_stage
   import csfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  rgb_type     rgb,
   output logic        free,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata
);

   logic    valid_ff, valid_in;
   rgb_type data_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rgb;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

[rtl/core/color_sensor_frame_parser.sv]
// Top level of the color sensor frame parser: input register, parser core
// and result register. Depends on csfp_pkg, csfp_parser and csfp_out_stage.
`timescale 1ns / 1ps

// Byte-serial parser for frames 0x5A 0x5A type count payload checksum, where
// the checksum is the 8-bit sum of every earlier frame byte. Feed one received
// byte per req transaction; a frame of type 0x45 with three payload bytes and
// a matching checksum yields one rsp transaction carrying red, green and blue.
// Any other frame, a broken second sync, or a count too long to finish within
// FRAME_BUF_BYTES frame bytes is dropped without output and the hunt restarts.
// The block takes one byte every clock cycle unless stalled as below. After the
// input register takes the checksum byte, the single-pass parser loads the
// result register from it and rsp_tvalid rises. Input stalls only while the
// result register holds a result the sink has not taken.

module color_sensor_frame_parser
   import csfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       req_take;
   logic       step;
   logic       free;
   logic       hit;
   rgb_type    rgb;

   // Advance the held byte through the parser once the result side has room
   assign step       = in_valid_ff && free;
   assign req_tready = !in_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;

   // Hold the byte until the parser consumes it; refill in the same cycle
   assign in_valid_in = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
      end
   end

   csfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .hit     (hit),
      .rgb     (rgb)
   );

   // Load a result only for a good RGB frame; drop everything else
   csfp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step && hit),
      .rgb        (rgb),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input byte lost before the parser took it");

endmodule

[tb/tb.sv]
// Self-checking testbench for color_sensor_frame_parser: directed and random
// byte streams with a built-in frame predictor. Depends on csfp_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
   import csfp_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 700;
   localparam int STEADY_ITEMS = 150;
   localparam int SETTLE       = 12;   // margin after the final drain before finishing
   localparam int IDLE_PCT     = 37;

   typedef logic [7:0] octet_q [$];

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // [7:0] red, [15:8] green, [23:16] blue

   int error_count = 0;
   int items_sent  = 0;
   int cycle_count = 0;
   bit steady_flow = 1'b0;            // suppress idles on both channels

   // Frame predictor state
   phase_type  frm_phase = PH_HUNT;
   int         frm_bytes = 0;
   logic [7:0] frm_kind  = 8'h00;
   logic [7:0] frm_len   = 8'h00;
   logic [7:0] frm_sum   = 8'h00;
   logic [7:0] frm_head [HEAD_DEPTH];
   rgb_type    rgb_expected [$];

   color_sensor_frame_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Watchdog: abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      $display("tb: error at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic restart_hunt();
      frm_phase = PH_HUNT;
      frm_bytes = 0;
   endtask

   // Advance the predictor by one accepted byte; queue an RGB result when a
   // good color frame closes.
   task automatic parse_rx_byte(input logic [7:0] rx);
      int      n;
      rgb_type rgb;
      if (frm_phase == PH_SYNC2) begin
         if (rx == SYNC_BYTE) begin
            frm_phase = PH_BODY;
            frm_bytes = 2;
            frm_sum   = SYNC_BYTE + SYNC_BYTE;
         end else begin
            restart_hunt();
         end
      end else if (frm_phase != PH_BODY) begin
         if (rx == SYNC_BYTE) begin
            frm_phase = PH_SYNC2;
            frm_bytes = 1;
         end else begin
            frm_phase = PH_HUNT;
         end
      end else begin
         n = frm_bytes + 1;
         frm_bytes = n;
         if (n == TYPE_POS) begin
            frm_kind = rx;
            frm_sum += rx;
         end else if (n == COUNT_POS) begin
            frm_len = rx;
            frm_sum += rx;
            if (n >= FRAME_BUF_BYTES) restart_hunt();
         end else if (frm_len <= COUNT_LIMIT && n >= frm_len + HEAD_BYTES + 1) begin
            // checksum position: emit only a clean color frame
            if (frm_sum == rx && frm_kind == RGB_TYPE && frm_len == RGB_COUNT) begin
               rgb.red   = frm_head[0];
               rgb.green = frm_head[1];
               rgb.blue  = frm_head[2];
               rgb_expected.push_back(rgb);
            end
            restart_hunt();
         end else if (n >= FRAME_BUF_BYTES) begin
            restart_hunt();
         end else begin
            frm_sum += rx;
            if (n >= HEAD_BYTES + 1 && n - (HEAD_BYTES + 1) < HEAD_DEPTH)
               frm_head[n - (HEAD_BYTES + 1)] = rx;
         end
      end
   endtask

   // Send one byte as a req transaction. Entered and left at a falling edge;
   // tvalid is left high, so callers drop it before any wait.
   task automatic send_byte(input logic [7:0] rx);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      parse_rx_byte(rx);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold off the sender until every predicted result has been taken
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (rgb_expected.size() != 0) @(negedge clock);
   endtask

   // Send a frame; the checksum is XORed with flip to corrupt it on demand
   task automatic send_frame(input logic [7:0] kind, input logic [7:0] cnt,
                             input octet_q body, input bit with_sum,
                             input logic [7:0] flip);
      logic [7:0] sum;
      sum = SYNC_BYTE + SYNC_BYTE + kind + cnt;
      send_byte(SYNC_BYTE);
      send_byte(SYNC_BYTE);
      send_byte(kind);
      send_byte(cnt);
      foreach (body[i]) begin
         send_byte(body[i]);
         sum += body[i];
      end
      if (with_sum) send_byte(sum ^ flip);
   endtask

   function automatic logic [7:0] rand_octet();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return SYNC_BYTE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // One random chunk of traffic: mostly well-formed color frames, plus
   // other frame kinds, overlong counts, broken syncs and line noise.
   task automatic rand_frame();
      octet_q     body;
      int         pick;
      int         len;
      logic [7:0] kind;
      logic [7:0] cnt;
      logic [7:0] flip;
      logic [7:0] junk;
      pick = $urandom_range(99);
      flip = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      if (pick < 55) begin
         repeat (RGB_COUNT) body.push_back(rand_octet());
         send_frame(RGB_TYPE, RGB_COUNT, body, 1'b1, flip);
      end else if (pick < 70) begin
         // color type or a random type, with a random length below the limit
         cnt  = 8'($urandom_range(COUNT_LIMIT - 1));
         kind = $urandom_range(1) ? RGB_TYPE : rand_octet();
         repeat (cnt) body.push_back(rand_octet());
         send_frame(kind, cnt, body, 1'b1, flip);
      end else if (pick < 80) begin
         // count too long to finish: absorbed up to the frame limit
         cnt = 8'($urandom_range(COUNT_LIMIT, 255));
         len = FRAME_BUF_BYTES - HEAD_BYTES;
         if ($urandom_range(3) == 0) len = $urandom_range(len);
         repeat (len) body.push_back(rand_octet());
         send_frame(rand_octet(), cnt, body, 1'b0, 8'h00);
      end else if (pick < 88) begin
         do junk = rand_octet(); while (junk == SYNC_BYTE);
         send_byte(SYNC_BYTE);
         send_byte(junk);
      end else begin
         repeat ($urandom_range(1, 4)) send_byte(rand_octet());
      end
   endtask

   // Payload extremes and a sync value inside the body
   task automatic test_rgb_extremes();
      send_frame(RGB_TYPE, RGB_COUNT, '{8'h00, 8'hFF, SYNC_BYTE}, 1'b1, 8'h00);
      send_frame(RGB_TYPE, RGB_COUNT, '{8'hFF, 8'h00, 8'hA5}, 1'b1, 8'h00);
   endtask

   // Lost second sync: the breaking byte is not rescanned
   task automatic test_sync_loss();
      send_byte(8'h00);
      send_byte(SYNC_BYTE);
      send_byte(8'h5B);
   endtask

   // Bad checksum, then an overlong count, then a good frame to show recovery
   task automatic test_dropped_frames();
      octet_q filler;
      send_frame(RGB_TYPE, RGB_COUNT, '{8'h12, 8'h34, 8'h56}, 1'b1, 8'h01);
      repeat (FRAME_BUF_BYTES - HEAD_BYTES) filler.push_back(SYNC_BYTE);
      send_frame(RGB_TYPE, COUNT_LIMIT, filler, 1'b0, 8'h00);
      send_frame(RGB_TYPE, RGB_COUNT, '{8'h80, 8'h7F, 8'h01}, 1'b1, 8'h00);
   endtask

   task automatic test_random_traffic(input int n_items);
      int target;
      target = items_sent + n_items;
      while (items_sent < target) rand_frame();
   endtask

   // Stop sending until the result channel is empty, then resume
   task automatic test_drain_pause();
      repeat (3) send_frame(RGB_TYPE, RGB_COUNT,
                            '{rand_octet(), rand_octet(), rand_octet()}, 1'b1, 8'h00);
      wait_drained();
      send_frame(RGB_TYPE, RGB_COUNT, '{8'hC3, 8'h3C, 8'h99}, 1'b1, 8'h00);
   endtask

   // Back-to-back traffic with no idles on either side
   task automatic test_steady_stream();
      steady_flow = 1'b1;
      test_random_traffic(STEADY_ITEMS);
      steady_flow = 1'b0;
   endtask

   // Sink: stall rsp at random unless the steady stretch is running
   always @(negedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
   end

   // Result checker: compare each rsp transaction with the oldest prediction
   always @(posedge clock) begin
      rgb_type got;
      rgb_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (rgb_expected.size() == 0) begin
            report_error($sformatf("unexpected result %06h", rsp_tdata));
         end else begin
            want = rgb_expected.pop_front();
            if (got.red !== want.red)
               report_error($sformatf("red %02h, want %02h", got.red, want.red));
            if (got.green !== want.green)
               report_error($sformatf("green %02h, want %02h", got.green, want.green));
            if (got.blue !== want.blue)
               report_error($sformatf("blue %02h, want %02h", got.blue, want.blue));
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_rgb_extremes();
      test_sync_loss();
      test_dropped_frames();
      test_random_traffic(RANDOM_ITEMS / 2);
      test_drain_pause();
      test_steady_stream();
      test_random_traffic(RANDOM_ITEMS / 2);

      // Drop tvalid, collect what is still in flight, then let the pipe settle
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

[color_sensor_frame_parser.f]
rtl/core/csfp_pkg.sv
rtl/core/csfp_parser.sv
rtl/core/csfp_out_stage.sv
rtl/core/color_sensor_frame_parser.sv
tb/tb.sv
